/* hw/rtl/skf_pkg.sv */
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and the microcode program of the scalar Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned ACC_W      = 51;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [GAIN_W-1:0]    GainOne     = 17'h10000;
  localparam logic [DATA_W-1:0]    VarOne      = 32'h0001_0000;
  localparam logic [DATA_W-1:0]    PvReset     = 32'd655;
  localparam logic [DATA_W-1:0]    MvReset     = 32'd6554;
  localparam logic [DIV_CNT_W-1:0] DivFirst    = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CfgInitEst  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CfgProcVar  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CfgMeasVar  = 2'd2;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_PRED,
    OP_DEN,
    OP_DIV,
    OP_GAIN,
    OP_MUL_DLO,
    OP_MUL_DHI,
    OP_EST,
    OP_MUL_PLO,
    OP_MUL_PHI,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_DIV,
    HOLD_OUT
  } hold_e;

  typedef struct packed {
    op_e   op;
    hold_e hold;
    logic  last;
  } ctrl_t;

  typedef struct packed {
    logic in_req;
    logic div_done;
    logic out_free;
  } stat_t;

  function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
    ctrl_t w;
    unique case (step)
      4'd0:    w = '{op: OP_IDLE,    hold: HOLD_IN,   last: 1'b0};
      4'd1:    w = '{op: OP_PRED,    hold: HOLD_NONE, last: 1'b0};
      4'd2:    w = '{op: OP_DEN,     hold: HOLD_NONE, last: 1'b0};
      4'd3:    w = '{op: OP_DIV,     hold: HOLD_DIV,  last: 1'b0};
      4'd4:    w = '{op: OP_GAIN,    hold: HOLD_NONE, last: 1'b0};
      4'd5:    w = '{op: OP_MUL_DLO, hold: HOLD_NONE, last: 1'b0};
      4'd6:    w = '{op: OP_MUL_DHI, hold: HOLD_NONE, last: 1'b0};
      4'd7:    w = '{op: OP_EST,     hold: HOLD_NONE, last: 1'b0};
      4'd8:    w = '{op: OP_MUL_PLO, hold: HOLD_NONE, last: 1'b0};
      4'd9:    w = '{op: OP_MUL_PHI, hold: HOLD_NONE, last: 1'b0};
      4'd10:   w = '{op: OP_EMIT,    hold: HOLD_OUT,  last: 1'b1};
      default: w = '{op: OP_IDLE,    hold: HOLD_IN,   last: 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/skf_seq.sv */
// ----------------------------------------------------------------------------
// skf_seq
// Step counter and microcode ROM; holds a step until its condition is met.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire skf_pkg::stat_t stat_i,
  output skf_pkg::ctrl_t      ctrl_o
);

  logic [skf_pkg::STEP_W-1:0] step_q, step_d;
  logic                       advance;

  assign ctrl_o = skf_pkg::ucode(step_q);

  always_comb begin
    unique case (ctrl_o.hold)
      skf_pkg::HOLD_NONE: advance = 1'b1;
      skf_pkg::HOLD_IN:   advance = stat_i.in_req;
      skf_pkg::HOLD_DIV:  advance = stat_i.div_done;
      skf_pkg::HOLD_OUT:  advance = stat_i.out_free;
      default:            advance = 1'b0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (advance) begin
      step_d = ctrl_o.last ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/scalar_kalman_filter.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional fixed-point Kalman filter run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed Q16.16 measurement per request. m_axis returns
//   one result per measurement: estimate, error variance and gain.
//   The cfg channel writes the initial estimate (0), the process noise (1)
//   and the measurement noise (2); writing index 0 restarts the filter with
//   variance 1.0. Other indexes are ignored. Write only while idle.
//   A measurement is taken only in the idle step, so one item is in flight at
//   a time; its result is registered when the last step emits it. The
//   17-step restoring gain divider and the 18x18 multiplier, used four times
//   per item in 16-bit halves, form the gain and the update.
//   Reset: estimate 0, variance 1.0, process variance 655, measurement
//   variance 6554, no result pending.
//   A stalled receiver keeps the result in the output register; the next
//   measurement is still accepted and processed, and the sequencer waits in
//   its last step until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] measurement
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // [31:0] estimate, [63:32] error_variance,
                                           // [80:64] gain, [87:81] zero
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned DW = skf_pkg::DATA_W;
  localparam int unsigned GW = skf_pkg::GAIN_W;
  localparam int unsigned AW = skf_pkg::ACC_W;

  skf_pkg::ctrl_t ctrl;
  skf_pkg::stat_t stat;

  logic in_acc, out_free, cfg_we;

  // filter state and registers
  logic [DW-1:0] est_q, est_d, var_q, var_d, pv_q, mv_q;
  // datapath
  logic [DW-1:0]            meas_q, pred_q, pred_d;
  logic [DW:0]              den_q, den_d, diff_q, diff_d, rem_q, rem_d;
  logic [GW-1:0]            quot_q, quot_d, gain_q, gain_d, omg;
  logic [skf_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]            acc_q, acc_d, prod_ext, prod_sh;
  logic [DW+1:0]            r_sh, r_sub;
  logic                     r_ge;
  logic [DW:0]              pv_sum;
  logic [DW+1:0]            est_sh;
  logic [DW+2:0]            est_sum;
  logic [DW-1:0]            est_new, var_new;
  logic signed [17:0]       mul_a, mul_b;
  logic signed [35:0]       prod;
  logic [80:0]              out_q;
  logic                     out_valid_q;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (ctrl.op == skf_pkg::OP_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;

  assign stat = '{in_req: in_acc, div_done: (cnt_q == '0), out_free: out_free};

  skf_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // predict, gain denominator and measurement residual
  assign pv_sum = {1'b0, var_q} + {1'b0, pv_q};
  assign pred_d = pv_sum[DW] ? '1 : pv_sum[DW-1:0];
  assign den_d  = {1'b0, pred_q} + {1'b0, mv_q};
  assign diff_d = {meas_q[DW-1], meas_q} - {est_q[DW-1], est_q};

  // restoring divide step; the only nonzero numerator bit left is pred[0]
  assign r_sh  = {rem_q, (cnt_q == skf_pkg::DivFirst) ? pred_q[0] : 1'b0};
  assign r_sub = r_sh - {1'b0, den_q};
  assign r_ge  = (r_sh >= {1'b0, den_q});
  assign gain_d = (den_q == '0) ? '0 : quot_q;
  assign omg    = skf_pkg::GainOne - gain_q;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    if (ctrl.op == skf_pkg::OP_DEN) begin
      rem_d  = {2'b0, pred_q[DW-1:1]};
      quot_d = '0;
      cnt_d  = skf_pkg::DivFirst;
    end else if (ctrl.op == skf_pkg::OP_DIV) begin
      rem_d  = r_ge ? r_sub[DW:0] : r_sh[DW:0];
      quot_d = {quot_q[GW-2:0], r_ge};
      if (cnt_q != '0) begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // shared multiplier, operands in 16-bit halves
  always_comb begin
    mul_a = $signed({1'b0, gain_q});
    mul_b = '0;
    unique case (ctrl.op)
      skf_pkg::OP_MUL_DLO: mul_b = $signed({2'b0, diff_q[15:0]});
      skf_pkg::OP_MUL_DHI: mul_b = $signed({diff_q[DW], diff_q[DW:16]});
      skf_pkg::OP_MUL_PLO: begin
        mul_a = $signed({1'b0, omg});
        mul_b = $signed({2'b0, pred_q[15:0]});
      end
      skf_pkg::OP_MUL_PHI: begin
        mul_a = $signed({1'b0, omg});
        mul_b = $signed({2'b0, pred_q[DW-1:16]});
      end
      default: mul_b = '0;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = {{(AW-36){prod[35]}}, prod};
  assign prod_sh  = {prod[34:0], 16'b0};

  always_comb begin
    unique case (ctrl.op)
      skf_pkg::OP_MUL_DLO, skf_pkg::OP_MUL_PLO: acc_d = prod_ext;
      skf_pkg::OP_MUL_DHI, skf_pkg::OP_MUL_PHI: acc_d = acc_q + prod_sh;
      default:                                  acc_d = acc_q;
    endcase
  end

  // update: floor shift of the correction, clamp to 32 bits
  assign est_sh  = acc_q[49:16];
  assign est_sum = {{3{est_q[DW-1]}}, est_q} + {est_sh[DW+1], est_sh};
  always_comb begin
    if (est_sum[DW+2:DW-1] == '0 || est_sum[DW+2:DW-1] == '1) begin
      est_new = est_sum[DW-1:0];
    end else begin
      est_new = est_sum[DW+2] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end
  assign var_new = acc_q[47:16];

  always_comb begin
    est_d = est_q;
    var_d = var_q;
    if (cfg_we && cfg_index_i == skf_pkg::CfgInitEst) begin
      est_d = cfg_data_i;
      var_d = skf_pkg::VarOne;
    end else begin
      if (ctrl.op == skf_pkg::OP_EST) begin
        est_d = est_new;
      end
      if (ctrl.op == skf_pkg::OP_EMIT && out_free) begin
        var_d = var_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q       <= '0;
      var_q       <= skf_pkg::VarOne;
      pv_q        <= skf_pkg::PvReset;
      mv_q        <= skf_pkg::MvReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      est_q <= est_d;
      var_q <= var_d;
      cnt_q <= cnt_d;
      if (cfg_we && cfg_index_i == skf_pkg::CfgProcVar) begin
        pv_q <= cfg_data_i;
      end
      if (cfg_we && cfg_index_i == skf_pkg::CfgMeasVar) begin
        mv_q <= cfg_data_i;
      end
      if (ctrl.op == skf_pkg::OP_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas_q <= s_axis_tdata;
    end
    if (ctrl.op == skf_pkg::OP_PRED) begin
      pred_q <= pred_d;
    end
    if (ctrl.op == skf_pkg::OP_DEN) begin
      den_q  <= den_d;
      diff_q <= diff_d;
    end
    if (ctrl.op == skf_pkg::OP_GAIN) begin
      gain_q <= gain_d;
    end
    rem_q  <= rem_d;
    quot_q <= quot_d;
    acc_q  <= acc_d;
    if (ctrl.op == skf_pkg::OP_EMIT && out_free) begin
      out_q <= {gain_q, var_new, est_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q};

  // assertions
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q[80:64] <= skf_pkg::GainOne))
    else $error("gain above one");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second measurement taken while busy");

  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == skf_pkg::OP_GAIN && den_q == '0) |=> (gain_q == '0))
    else $error("nonzero gain with zero denominator");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == skf_pkg::OP_GAIN) |-> (cnt_q == '0))
    else $error("gain taken before divide finished");

endmodule

`default_nettype wire
